>>> rtl/c8alu_pkg.sv
// types and operation codes shared by the 8-bit alu with flags
`default_nettype none

package c8alu_pkg;

	// operation codes
	localparam logic [4:0] ACT_ADD  = 5'd0;
	localparam logic [4:0] ACT_ADC  = 5'd1;
	localparam logic [4:0] ACT_SUB  = 5'd2;
	localparam logic [4:0] ACT_SBC  = 5'd3;
	localparam logic [4:0] ACT_AND  = 5'd4;
	localparam logic [4:0] ACT_XOR  = 5'd5;
	localparam logic [4:0] ACT_OR   = 5'd6;
	localparam logic [4:0] ACT_CP   = 5'd7;
	localparam logic [4:0] ACT_INC  = 5'd8;
	localparam logic [4:0] ACT_DEC  = 5'd9;
	localparam logic [4:0] ACT_RLC  = 5'd10;
	localparam logic [4:0] ACT_RRC  = 5'd11;
	localparam logic [4:0] ACT_RL   = 5'd12;
	localparam logic [4:0] ACT_RR   = 5'd13;
	localparam logic [4:0] ACT_SLA  = 5'd14;
	localparam logic [4:0] ACT_SRA  = 5'd15;
	localparam logic [4:0] ACT_SWAP = 5'd16;
	localparam logic [4:0] ACT_SRL  = 5'd17;
	localparam logic [4:0] ACT_RLCA = 5'd18;
	localparam logic [4:0] ACT_RRCA = 5'd19;
	localparam logic [4:0] ACT_RLA  = 5'd20;
	localparam logic [4:0] ACT_RRA  = 5'd21;
	localparam logic [4:0] ACT_BIT  = 5'd22;
	localparam logic [4:0] ACT_SET  = 5'd23;
	localparam logic [4:0] ACT_RES  = 5'd24;
	localparam logic [4:0] ACT_DAA  = 5'd25;
	localparam logic [4:0] ACT_CPL  = 5'd26;
	localparam logic [4:0] ACT_SCF  = 5'd27;
	localparam logic [4:0] ACT_CCF  = 5'd28;

	// flag bit positions
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	// decimal adjust constants
	localparam logic [7:0] DAA_HI_ADJ = 8'h60;
	localparam logic [7:0] DAA_LO_ADJ = 8'h06;
	localparam logic [7:0] DAA_HI_MAX = 8'h99;
	localparam logic [3:0] DAA_LO_MAX = 4'd9;

	typedef struct packed {
		logic [4:0] action;
		logic [7:0] operand_a;
		logic [7:0] operand_b;
		logic [2:0] bit_index;
		logic [3:0] flags_in;
	} c8alu_in_t;

	typedef struct packed {
		logic [7:0] result;
		logic [3:0] flags_out;
		logic       writes_result;
	} c8alu_out_t;

endpackage

`default_nettype wire

>>> rtl/cpu_8bit_alu_with_flags_core.sv
// 8-bit alu with z/n/h/c flags: input register, one pass of logic, result register
// an accepted item is held in the input register, then in the result register, from which it is delivered
// throughput: one item per cycle while res_stall is low, with one pass of combinational logic between the two registers
// a new item is taken while a finished result waits, as long as the input stage is free
// reset (arst_n low, asynchronous) empties both stages; payload registers are not reset
`default_nettype none

module cpu_8bit_alu_with_flags_core
	import c8alu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	// operation channel
	input  wire logic       op_valid,
	output logic            op_stall,
	input  wire c8alu_in_t  op,
	// result channel
	input  wire logic       res_stall,
	output logic            res_valid,
	output c8alu_out_t      res
);

	// input stage
	logic      v_s1;
	c8alu_in_t op_s1;

	// next result, built from the input stage
	c8alu_out_t res_nxt;

	// handshake: result register frees when empty or taken this cycle
	logic adv2;
	logic take;

	assign adv2     = !res_valid || !res_stall;
	// the input stage only backs up when it holds an item that cannot move on
	assign op_stall = v_s1 && !adv2;
	assign take     = op_valid && !op_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (!v_s1 || adv2) begin
				v_s1 <= op_valid;
			end
			if (adv2) begin
				res_valid <= v_s1;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= op;
		end
		if (adv2 && v_s1) begin
			res <= res_nxt;
		end
	end

	// ---------------------------------------------------------------
	// single pass of alu logic on the input stage
	// ---------------------------------------------------------------
	logic [7:0] a;
	logic [7:0] b;
	logic [3:0] fi;
	logic       cin;
	logic       use_c;      // carry enters add with carry or subtract with carry
	logic [8:0] sum9;
	logic [4:0] sum_lo;
	logic [8:0] dif9;
	logic [4:0] dif_lo;
	logic [7:0] bmask;
	logic [7:0] daa_val;
	logic       daa_c;
	logic [7:0] r;
	logic       fz_keep;    // zero flag forced low for accumulator rotates

	assign a   = op_s1.operand_a;
	assign b   = op_s1.operand_b;
	assign fi  = op_s1.flags_in;
	assign cin = fi[FLAG_C];

	assign use_c  = (op_s1.action == ACT_ADC) || (op_s1.action == ACT_SBC);
	assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, use_c & cin};
	assign sum_lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, use_c & cin};
	// bit 8 of the 9-bit difference is the borrow out
	assign dif9   = {1'b0, a} - {1'b0, b} - {8'd0, use_c & cin};
	assign dif_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, use_c & cin};

	assign bmask = 8'd1 << op_s1.bit_index;

	// decimal adjust after add or subtract
	always_comb begin
		daa_val = a;
		daa_c   = cin;
		if (!fi[FLAG_N]) begin
			if (cin || (a > DAA_HI_MAX)) begin
				daa_val = daa_val + DAA_HI_ADJ;
				daa_c   = 1'b1;
			end
			if (fi[FLAG_H] || (a[3:0] > DAA_LO_MAX)) begin
				daa_val = daa_val + DAA_LO_ADJ;
			end
		end else begin
			if (cin) begin
				daa_val = daa_val - DAA_HI_ADJ;
			end
			if (fi[FLAG_H]) begin
				daa_val = daa_val - DAA_LO_ADJ;
			end
		end
	end

	always_comb begin
		res_nxt.result        = a;
		res_nxt.flags_out     = fi;
		res_nxt.writes_result = 1'b1;
		r                     = a;
		fz_keep               = 1'b1;
		unique case (op_s1.action) inside
			ACT_ADD, ACT_ADC: begin
				r = sum9[7:0];
				res_nxt.flags_out = {(r == 8'd0), 1'b0, sum_lo[4], sum9[8]};
			end
			ACT_SUB, ACT_SBC, ACT_CP: begin
				r = dif9[7:0];
				res_nxt.flags_out = {(r == 8'd0), 1'b1, dif_lo[4], dif9[8]};
				res_nxt.writes_result = (op_s1.action != ACT_CP);
			end
			ACT_AND: begin
				r = a & b;
				res_nxt.flags_out = {(r == 8'd0), 1'b0, 1'b1, 1'b0};
			end
			ACT_XOR: begin
				r = a ^ b;
				res_nxt.flags_out = {(r == 8'd0), 3'b000};
			end
			ACT_OR: begin
				r = a | b;
				res_nxt.flags_out = {(r == 8'd0), 3'b000};
			end
			ACT_INC: begin
				r = a + 8'd1;
				res_nxt.flags_out = {(r == 8'd0), 1'b0, (a[3:0] == 4'hF), cin};
			end
			ACT_DEC: begin
				r = a - 8'd1;
				res_nxt.flags_out = {(r == 8'd0), 1'b1, (a[3:0] == 4'h0), cin};
			end
			ACT_RLC, ACT_RLCA: begin
				r = {a[6:0], a[7]};
				fz_keep = (op_s1.action == ACT_RLC);
				res_nxt.flags_out = {fz_keep && (r == 8'd0), 2'b00, a[7]};
			end
			ACT_RRC, ACT_RRCA: begin
				r = {a[0], a[7:1]};
				fz_keep = (op_s1.action == ACT_RRC);
				res_nxt.flags_out = {fz_keep && (r == 8'd0), 2'b00, a[0]};
			end
			ACT_RL, ACT_RLA: begin
				r = {a[6:0], cin};
				fz_keep = (op_s1.action == ACT_RL);
				res_nxt.flags_out = {fz_keep && (r == 8'd0), 2'b00, a[7]};
			end
			ACT_RR, ACT_RRA: begin
				r = {cin, a[7:1]};
				fz_keep = (op_s1.action == ACT_RR);
				res_nxt.flags_out = {fz_keep && (r == 8'd0), 2'b00, a[0]};
			end
			ACT_SLA: begin
				r = {a[6:0], 1'b0};
				res_nxt.flags_out = {(r == 8'd0), 2'b00, a[7]};
			end
			ACT_SRA: begin
				r = {a[7], a[7:1]};
				res_nxt.flags_out = {(r == 8'd0), 2'b00, a[0]};
			end
			ACT_SWAP: begin
				r = {a[3:0], a[7:4]};
				res_nxt.flags_out = {(r == 8'd0), 3'b000};
			end
			ACT_SRL: begin
				r = {1'b0, a[7:1]};
				res_nxt.flags_out = {(r == 8'd0), 2'b00, a[0]};
			end
			ACT_BIT: begin
				res_nxt.flags_out = {((a & bmask) == 8'd0), 1'b0, 1'b1, cin};
				res_nxt.writes_result = 1'b0;
			end
			ACT_SET: begin
				r = a | bmask;
			end
			ACT_RES: begin
				r = a & ~bmask;
			end
			ACT_DAA: begin
				r = daa_val;
				res_nxt.flags_out = {(r == 8'd0), fi[FLAG_N], 1'b0, daa_c};
			end
			ACT_CPL: begin
				r = ~a;
				res_nxt.flags_out = {fi[FLAG_Z], 1'b1, 1'b1, cin};
			end
			ACT_SCF: begin
				res_nxt.flags_out = {fi[FLAG_Z], 2'b00, 1'b1};
			end
			ACT_CCF: begin
				res_nxt.flags_out = {fi[FLAG_Z], 2'b00, !cin};
			end
			default: begin
				// unused codes pass operand and flags, nothing written
				res_nxt.writes_result = 1'b0;
			end
		endcase
		res_nxt.result = r;
	end

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
`ifndef SYNTHESIS
	// back-pressure only when both stages hold an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		op_stall |-> (v_s1 && res_valid))
		else $error("input stalled with a free stage");

	// an accepted item lands in the input stage
	a_take_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(op_valid && !op_stall) |=> v_s1)
		else $error("accepted item lost");

	// compare and bit test never write back
	a_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv2 && ((op_s1.action == ACT_CP) || (op_s1.action == ACT_BIT)))
		|=> (res_valid && !res.writes_result))
		else $error("compare or bit test marked for write back");
`endif

endmodule

`default_nettype wire
